// ===== sv/mea_pkg.sv =====
// Shared types, codes and sizing constants of the mesh edge adjacency builder.
`timescale 1ns / 1ps
package mea_pkg;

  localparam int MAX_VERTICES_DEF  = 1024;
  localparam int MAX_TRIANGLES_DEF = 1024;
  localparam int COORD_BITS_DEF    = 16;

  localparam int IDX_W  = 10;  // vertex index field width
  localparam int COORD_W = 16; // coordinate field width
  localparam int SLOT_W = 12;  // half-edge slot field width

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_OPEN     = 2'd1;
  localparam logic [1:0] ST_UNFILLED = 2'd2;

  // one stored half-edge
  typedef struct packed {
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] e;
    logic [IDX_W-1:0] o;
  } hedge_t;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       vload;
    logic       fetch_en;
    logic [1:0] fetch_sel;
    logic       mul_en;
    logic [3:0] mul_step;
    logic       set_flip;
    logic       he_write;
    logic [1:0] he_sel;
    logic       tri_inc;
    logic       q_read;
    logic       q_latch;
    logic       scan_step;
    logic       res_unfilled;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic norm_en;
    logic slot_filled;
    logic hit;
    logic miss;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/mea_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mea_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/mea_ctrl.sv =====
// Sequencer for vertex loads, triangle adds and twin-edge queries.
`timescale 1ns / 1ps
module mea_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    opcode,
  input  mea_pkg::stat_t st,
  output mea_pkg::cmd_t  cmd
);
  import mea_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ADD_CHK = 4'd1;
  localparam logic [3:0] S_FETCH   = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_MDRAIN  = 4'd4;
  localparam logic [3:0] S_MSIGN   = 4'd5;
  localparam logic [3:0] S_WRITE   = 4'd6;
  localparam logic [3:0] S_Q_CHK   = 4'd7;
  localparam logic [3:0] S_Q_LATCH = 4'd8;
  localparam logic [3:0] S_SCAN    = 4'd9;
  localparam logic [3:0] S_RESULT  = 4'd10;

  localparam logic [3:0] FETCH_LAST = 4'd3;
  localparam logic [3:0] MUL_LAST   = 4'd11;
  localparam logic [3:0] WRITE_LAST = 4'd2;

  logic [3:0] state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          case (opcode)
            OP_LOAD:  cmd.vload = 1'b1;
            OP_ADD:   state_next = S_ADD_CHK;
            OP_QUERY: state_next = S_Q_CHK;
            default:  cmd.clear = 1'b1;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (st.full) begin
          state_next = S_IDLE;
        end else if (st.norm_en) begin
          state_next = S_FETCH;
        end else begin
          cmd.set_flip = 1'b1;
          state_next   = S_WRITE;
        end
      end
      S_FETCH: begin
        cmd.fetch_en  = (cnt != FETCH_LAST);
        cmd.fetch_sel = cnt[1:0];
        cnt_next      = cnt + 4'd1;
        if (cnt == FETCH_LAST) begin
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = cnt;
        cnt_next     = cnt + 4'd1;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = S_MDRAIN;
        end
      end
      S_MDRAIN: state_next = S_MSIGN;
      S_MSIGN: begin
        cmd.set_flip = 1'b1;
        state_next   = S_WRITE;
      end
      S_WRITE: begin
        cmd.he_write = 1'b1;
        cmd.he_sel   = cnt[1:0];
        cnt_next     = cnt + 4'd1;
        if (cnt == WRITE_LAST) begin
          cmd.tri_inc = 1'b1;
          cnt_next    = '0;
          state_next  = S_IDLE;
        end
      end
      S_Q_CHK: begin
        if (st.slot_filled) begin
          cmd.q_read = 1'b1;
          state_next = S_Q_LATCH;
        end else begin
          cmd.res_unfilled = 1'b1;
          state_next       = S_RESULT;
        end
      end
      S_Q_LATCH: begin
        cmd.q_latch = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.hit || st.miss) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && (st.hit || st.miss)) |=> (state == S_RESULT))
    else $error("scan did not hand over to result");
  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (cnt <= MUL_LAST))
    else $error("multiply step out of range");
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    cmd.tri_inc |-> (state == S_WRITE && cnt == WRITE_LAST))
    else $error("triangle counted before all half-edges written");
endmodule

// ===== sv/mea_dpath.sv =====
// Vertex stores, exact winding test, half-edge table and twin scan.
`timescale 1ns / 1ps
module mea_dpath #(
  parameter int MAX_VERTICES  = mea_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = mea_pkg::MAX_TRIANGLES_DEF,
  parameter int COORD_BITS    = mea_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mea_pkg::cmd_t               cmd,
  output mea_pkg::stat_t              st,
  input  logic                        cfg_write_en,
  input  logic                        cfg_write_data,
  input  logic [mea_pkg::IDX_W-1:0]   vertex_slot,
  input  logic [mea_pkg::COORD_W-1:0] pos_x,
  input  logic [mea_pkg::COORD_W-1:0] pos_y,
  input  logic [mea_pkg::COORD_W-1:0] pos_z,
  input  logic [mea_pkg::COORD_W-1:0] norm_x,
  input  logic [mea_pkg::COORD_W-1:0] norm_y,
  input  logic [mea_pkg::COORD_W-1:0] norm_z,
  input  logic [mea_pkg::IDX_W-1:0]   corner_one,
  input  logic [mea_pkg::IDX_W-1:0]   corner_two,
  input  logic [mea_pkg::IDX_W-1:0]   corner_three,
  input  logic [mea_pkg::SLOT_W-1:0]  half_edge_slot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mea_pkg::IDX_W-1:0]   edge_start,
  output logic [mea_pkg::IDX_W-1:0]   opposite_vertex,
  output logic [1:0]                  status
);
  import mea_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int VA   = $clog2(MAX_VERTICES);
  localparam int HD   = 3 * MAX_TRIANGLES;
  localparam int HW   = $clog2(HD);
  localparam int CTW  = $clog2(MAX_TRIANGLES + 1);
  localparam int FW   = $clog2(HD + 1);
  localparam int SW   = HW + SLOT_W;
  localparam int K    = CW + 2;        // low split of a cross component
  localparam int AW   = CW + 3;
  localparam int BW   = CW + 1;
  localparam int PW   = AW + BW;
  localparam int CRW  = 2 * CW + 3;
  localparam int DW   = 3 * CW + 6;

  // config and counters
  logic          norm_en;
  logic [CTW-1:0] tri_count;
  logic [FW-1:0]  filled;

  // captured item
  logic [IDX_W-1:0]  cor [3];
  logic [SLOT_W-1:0] q_slot;

  // vertex stores
  logic [3*CW-1:0] pos_wdata, nrm_wdata, pos_rdata, nrm_rdata;
  logic [VA-1:0]   v_addr;
  logic            v_we;
  logic [IDX_W-1:0] fetch_idx;

  assign pos_wdata = {CW'(pos_z), CW'(pos_y), CW'(pos_x)};
  assign nrm_wdata = {CW'(norm_z), CW'(norm_y), CW'(norm_x)};
  assign v_we      = cmd.vload && (vertex_slot < MAX_VERTICES);
  assign fetch_idx = (cmd.fetch_sel == 2'd2) ? cor[2] :
                     (cmd.fetch_sel == 2'd1) ? cor[1] : cor[0];
  assign v_addr    = cmd.vload ? VA'(vertex_slot) : VA'(fetch_idx);

  mea_ram #(.W(3*CW), .D(MAX_VERTICES)) u_pos_ram (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(pos_wdata), .rdata(pos_rdata)
  );
  mea_ram #(.W(3*CW), .D(MAX_VERTICES)) u_nrm_ram (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(nrm_wdata), .rdata(nrm_rdata)
  );

  // fetch pipeline: data lands in the cycle after the read is issued
  logic       f_vld, f_rng;
  logic [1:0] f_sel;
  logic signed [CW-1:0] va [3], vb [3], vc [3], vn [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= cmd.fetch_en;
    end
    f_sel <= cmd.fetch_sel;
    f_rng <= (fetch_idx < MAX_VERTICES);
    if (f_vld) begin
      for (int i = 0; i < 3; i++) begin
        case (f_sel)
          2'd0: begin
            va[i] <= f_rng ? pos_rdata[i*CW +: CW] : '0;
            vn[i] <= f_rng ? nrm_rdata[i*CW +: CW] : '0;
          end
          2'd1:    vb[i] <= f_rng ? pos_rdata[i*CW +: CW] : '0;
          default: vc[i] <= f_rng ? pos_rdata[i*CW +: CW] : '0;
        endcase
      end
    end
  end

  // exact sign of dot(cross(b-a, c-a), n) on one shared multiplier
  logic signed [BW-1:0]  u [3], v [3];
  logic signed [CRW-1:0] cr [3];
  logic signed [AW-1:0]  op_a;
  logic signed [BW-1:0]  op_b;
  logic signed [PW-1:0]  prod;
  logic [3:0]            p_step;
  logic                  p_vld;
  logic signed [DW-1:0]  dot;
  logic                  flip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = BW'(vb[i]) - BW'(va[i]);
      v[i] = BW'(vc[i]) - BW'(va[i]);
    end
    case (cmd.mul_step)
      4'd0:  begin op_a = AW'(u[1]); op_b = v[2]; end
      4'd1:  begin op_a = AW'(u[2]); op_b = v[1]; end
      4'd2:  begin op_a = AW'(u[2]); op_b = v[0]; end
      4'd3:  begin op_a = AW'(u[0]); op_b = v[2]; end
      4'd4:  begin op_a = AW'(u[0]); op_b = v[1]; end
      4'd5:  begin op_a = AW'(u[1]); op_b = v[0]; end
      4'd6:  begin op_a = {1'b0, cr[0][K-1:0]};         op_b = BW'(vn[0]); end
      4'd7:  begin op_a = AW'($signed(cr[0][CRW-1:K])); op_b = BW'(vn[0]); end
      4'd8:  begin op_a = {1'b0, cr[1][K-1:0]};         op_b = BW'(vn[1]); end
      4'd9:  begin op_a = AW'($signed(cr[1][CRW-1:K])); op_b = BW'(vn[1]); end
      4'd10: begin op_a = {1'b0, cr[2][K-1:0]};         op_b = BW'(vn[2]); end
      default: begin op_a = AW'($signed(cr[2][CRW-1:K])); op_b = BW'(vn[2]); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= cmd.mul_en;
    end
    prod   <= op_a * op_b;
    p_step <= cmd.mul_step;
    if (p_vld) begin
      case (p_step)
        4'd0:        cr[0] <= CRW'(prod);
        4'd1:        cr[0] <= cr[0] - CRW'(prod);
        4'd2:        cr[1] <= CRW'(prod);
        4'd3:        cr[1] <= cr[1] - CRW'(prod);
        4'd4:        cr[2] <= CRW'(prod);
        4'd5:        cr[2] <= cr[2] - CRW'(prod);
        4'd6:        dot <= DW'(prod);
        4'd8, 4'd10: dot <= dot + DW'(prod);
        default:     dot <= dot + (DW'(prod) <<< K);
      endcase
    end
    if (cmd.set_flip) begin
      flip <= norm_en && dot[DW-1];
    end
  end

  // half-edge table
  hedge_t         he_wdata, he_rdata, q_edge;
  logic [HW-1:0]  he_addr, he_waddr, he_raddr;
  logic [FW-1:0]  scan_j;
  logic           rd_vld;

  always_comb begin
    case (cmd.he_sel)
      2'd0:    he_wdata = flip ? {cor[1], cor[0], cor[2]} : {cor[0], cor[1], cor[2]};
      2'd1:    he_wdata = flip ? {cor[0], cor[2], cor[1]} : {cor[1], cor[2], cor[0]};
      default: he_wdata = flip ? {cor[2], cor[1], cor[0]} : {cor[2], cor[0], cor[1]};
    endcase
  end

  assign he_waddr = HW'(filled + FW'(cmd.he_sel));
  assign he_raddr = cmd.q_read ? HW'(q_slot) : HW'(scan_j);
  assign he_addr  = cmd.he_write ? he_waddr : he_raddr;

  mea_ram #(.W($bits(hedge_t)), .D(HD)) u_he_ram (
    .clk(clk), .we(cmd.he_write), .addr(he_addr), .wdata(he_wdata), .rdata(he_rdata)
  );

  // status to the controller
  logic scan_more;
  assign scan_more      = (scan_j < filled);
  assign st.full        = (tri_count == CTW'(MAX_TRIANGLES));
  assign st.norm_en     = norm_en;
  assign st.slot_filled = (SW'(q_slot) < SW'(filled));
  assign st.hit         = rd_vld && (he_rdata.s == q_edge.e) && (he_rdata.e == q_edge.s);
  assign st.miss        = !rd_vld && !scan_more;
  assign st.out_free    = !out_valid || !out_stall;

  // result staging and output register
  logic [IDX_W-1:0] res_start, res_opp;
  logic [1:0]       res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_en   <= 1'b1;
      tri_count <= '0;
      filled    <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        norm_en <= cfg_write_data;
      end
      if (cmd.clear) begin
        tri_count <= '0;
        filled    <= '0;
      end else if (cmd.tri_inc) begin
        tri_count <= tri_count + CTW'(1);
        filled    <= filled + FW'(3);
      end
      if (cmd.q_latch) begin
        rd_vld <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld <= scan_more;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (cmd.capture) begin
      cor[0] <= corner_one;
      cor[1] <= corner_two;
      cor[2] <= corner_three;
      q_slot <= half_edge_slot;
    end
    if (cmd.q_latch) begin
      q_edge <= he_rdata;
      scan_j <= '0;
    end else if (cmd.scan_step && scan_more) begin
      scan_j <= scan_j + FW'(1);
    end
    if (cmd.res_unfilled) begin
      res_start  <= '0;
      res_opp    <= '0;
      res_status <= ST_UNFILLED;
    end else if (cmd.scan_step && st.hit) begin
      res_start  <= q_edge.s;
      res_opp    <= he_rdata.o;
      res_status <= ST_FOUND;
    end else if (cmd.scan_step && st.miss) begin
      res_start  <= q_edge.s;
      res_opp    <= '0;
      res_status <= ST_OPEN;
    end
    if (cmd.out_load) begin
      edge_start      <= res_start;
      opposite_vertex <= res_opp;
      status          <= res_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tri_count <= CTW'(MAX_TRIANGLES))
    else $error("triangle count beyond table size");
  a_filled_tracks: assert property (@(posedge clk) disable iff (rst)
    32'(filled) == 3 * 32'(tri_count))
    else $error("filled slot count out of step with triangle count");
  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending transfer");
  a_add_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.tri_inc |-> !st.full)
    else $error("triangle added to full table");
endmodule

// ===== sv/mesh_edge_adjacency_builder_unit.sv =====
// Top level of the mesh edge adjacency builder.
`timescale 1ns / 1ps
// Mesh edge adjacency builder.
// Input channel (in_valid/in_stall) carries one command per transfer:
//   load vertex, add triangle, query half-edge, clear mesh. Only a query
//   returns a result, on the output channel (out_valid/out_stall).
// An add with winding correction on does three vertex store reads,
// twelve steps of the one shared multiplier for the exact cross/dot
// sign, then three half-edge table writes; with correction off it does
// only the writes. An add to a full table is dropped.
// A query's twin scan reads the half-edge table one slot per cycle
// and stops at the first twin or after the last filled slot; a query
// of an unfilled slot skips the scan.
// One command is worked at a time; in_stall is high while busy.
// The result sits in an output register; a stalled receiver only holds
// the block once a second query result is ready.
// Reset clears the triangle count and sets normals_present to 1. The
// vertex stores and half-edge table are not cleared; clear mesh only
// zeroes the triangle count and the filled-slot count.
// normals_present is written through cfg_write_en/cfg_write_data.
module mesh_edge_adjacency_builder_unit #(
  parameter int MAX_VERTICES  = mea_pkg::MAX_VERTICES_DEF,
  parameter int MAX_TRIANGLES = mea_pkg::MAX_TRIANGLES_DEF,
  parameter int COORD_BITS    = mea_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic                        cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [mea_pkg::IDX_W-1:0]   vertex_slot,
  input  logic [mea_pkg::COORD_W-1:0] pos_x,
  input  logic [mea_pkg::COORD_W-1:0] pos_y,
  input  logic [mea_pkg::COORD_W-1:0] pos_z,
  input  logic [mea_pkg::COORD_W-1:0] norm_x,
  input  logic [mea_pkg::COORD_W-1:0] norm_y,
  input  logic [mea_pkg::COORD_W-1:0] norm_z,
  input  logic [mea_pkg::IDX_W-1:0]   corner_one,
  input  logic [mea_pkg::IDX_W-1:0]   corner_two,
  input  logic [mea_pkg::IDX_W-1:0]   corner_three,
  input  logic [mea_pkg::SLOT_W-1:0]  half_edge_slot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mea_pkg::IDX_W-1:0]   edge_start,
  output logic [mea_pkg::IDX_W-1:0]   opposite_vertex,
  output logic [1:0]                  status
);
  import mea_pkg::*;

  cmd_t  cmd;
  stat_t st;

  mea_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .st(st), .cmd(cmd)
  );

  mea_dpath #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_TRIANGLES(MAX_TRIANGLES),
    .COORD_BITS(COORD_BITS)
  ) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .vertex_slot(vertex_slot),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .corner_one(corner_one), .corner_two(corner_two), .corner_three(corner_three),
    .half_edge_slot(half_edge_slot),
    .out_valid(out_valid), .out_stall(out_stall),
    .edge_start(edge_start), .opposite_vertex(opposite_vertex), .status(status)
  );
endmodule

// ===== dv/mesh_edge_adjacency_builder_unit_test.sv =====
// Self-checking bench for the mesh edge adjacency builder: commands in, query results checked.
`timescale 1ns / 1ps
module mesh_edge_adjacency_builder_unit_test;
  import mea_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic [IDX_W-1:0]   vslot;
    logic [COORD_W-1:0] p [3];
    logic [COORD_W-1:0] n [3];
    logic [IDX_W-1:0]   c [3];
    logic [SLOT_W-1:0]  hslot;
    bit                 is_cfg;
    bit                 cfg_val;
  } cmd_item_t;

  typedef struct {
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] opp;
    logic [1:0]       st;
  } adj_t;

  logic clk = 0, rst = 1;
  logic cfg_write_en = 0, cfg_write_data = 0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [1:0] opcode = 0;
  logic [IDX_W-1:0] vertex_slot = 0, corner_one = 0, corner_two = 0, corner_three = 0;
  logic [COORD_W-1:0] pos_x = 0, pos_y = 0, pos_z = 0, norm_x = 0, norm_y = 0, norm_z = 0;
  logic [SLOT_W-1:0] half_edge_slot = 0;
  logic [IDX_W-1:0] edge_start, opposite_vertex;
  logic [1:0] status;

  mesh_edge_adjacency_builder_unit u_top (.*);

  initial forever #6 clk = ~clk;

  // predictor state
  logic signed [COORD_W-1:0] vpos [1024][3];
  logic signed [COORD_W-1:0] vnrm [1024][3];
  hedge_t he_tab [3072];
  int unsigned tri_cnt = 0;
  bit norm_on = 1;
  bit loaded [1024];

  cmd_item_t pending [$];
  adj_t adj_expected [$];
  int errors = 0, mismatches = 0;
  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;
  bit in_fire = 0;

  function automatic bit flipped(logic [IDX_W-1:0] ia, ib, ic);
    logic signed [63:0] a[3], b[3], c[3], u[3], v[3], cr[3];
    logic signed [127:0] dot;
    for (int k = 0; k < 3; k++) begin
      a[k] = vpos[ia][k]; b[k] = vpos[ib][k]; c[k] = vpos[ic][k];
      u[k] = b[k] - a[k]; v[k] = c[k] - a[k];
    end
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    dot = 0;
    for (int k = 0; k < 3; k++) dot += 128'(cr[k]) * 128'($signed(vnrm[ia][k]));
    return dot < 0;
  endfunction

  task automatic apply_command(cmd_item_t t);
    adj_t r;
    hedge_t q;
    int unsigned filled;
    case (t.op)
      OP_LOAD: for (int k = 0; k < 3; k++) begin
        vpos[t.vslot][k] = t.p[k]; vnrm[t.vslot][k] = t.n[k];
      end
      OP_ADD: if (tri_cnt < 1024) begin
        int b;
        b = 3 * tri_cnt;
        if (norm_on && flipped(t.c[0], t.c[1], t.c[2])) begin
          he_tab[b]   = '{t.c[1], t.c[0], t.c[2]};
          he_tab[b+1] = '{t.c[0], t.c[2], t.c[1]};
          he_tab[b+2] = '{t.c[2], t.c[1], t.c[0]};
        end else begin
          he_tab[b]   = '{t.c[0], t.c[1], t.c[2]};
          he_tab[b+1] = '{t.c[1], t.c[2], t.c[0]};
          he_tab[b+2] = '{t.c[2], t.c[0], t.c[1]};
        end
        tri_cnt++;
      end
      OP_QUERY: begin
        filled = 3 * tri_cnt;
        if (t.hslot >= filled) r = '{0, 0, ST_UNFILLED};
        else begin
          q = he_tab[t.hslot];
          r = '{q.s, 0, ST_OPEN};
          for (int j = 0; j < filled; j++)
            if (he_tab[j].s == q.e && he_tab[j].e == q.s) begin
              r.opp = he_tab[j].o; r.st = ST_FOUND; break;
            end
        end
        adj_expected = {adj_expected, r};
      end
      default: tri_cnt = 0;
    endcase
  endtask

  // driver: a new item or a config write only after the last transfer went through
  always @(negedge clk) begin
    cmd_item_t t;
    bit send, cfg_now;
    cycles++;
    send = 0;
    cfg_now = 0;
    if (!rst && (!in_valid || in_fire) && pending.size() > 0) begin
      if (pending[0].is_cfg) begin
        // registers only change once the block has drained
        cfg_now = !in_valid && !in_stall && !out_valid && adj_expected.size() == 0;
      end else begin
        send = $urandom_range(99) >= send_idle;
      end
    end
    if (send) begin
      t = pending[0];
      opcode <= t.op; vertex_slot <= t.vslot;
      pos_x <= t.p[0]; pos_y <= t.p[1]; pos_z <= t.p[2];
      norm_x <= t.n[0]; norm_y <= t.n[1]; norm_z <= t.n[2];
      corner_one <= t.c[0]; corner_two <= t.c[1]; corner_three <= t.c[2];
      half_edge_slot <= t.hslot;
    end
    if (cfg_now) begin
      cfg_write_data <= pending[0].cfg_val;
      norm_on = pending[0].cfg_val;
      void'(pending.pop_front());
    end
    if (rst || !in_valid || in_fire) in_valid <= send;
    cfg_write_en <= cfg_now;
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // monitor
  always @(posedge clk) begin
    adj_t e;
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      apply_command(pending[0]);
      void'(pending.pop_front());
    end
    if (!rst && out_valid && !out_stall) begin
      if (adj_expected.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %0d %0d %0d",
                                        edge_start, opposite_vertex, status);
      end else begin
        e = adj_expected.pop_front();
        if (edge_start !== e.start || opposite_vertex !== e.opp || status !== e.st) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d", e.start, e.opp, e.st,
                     edge_start, opposite_vertex, status);
        end
      end
    end
  end

  function automatic cmd_item_t mk(logic [1:0] op);
    cmd_item_t t;
    t.op = op; t.vslot = 0; t.hslot = 0; t.is_cfg = 0; t.cfg_val = 0;
    for (int k = 0; k < 3; k++) begin t.p[k] = 0; t.n[k] = 0; t.c[k] = 0; end
    return t;
  endfunction

  function automatic cmd_item_t pick_coord(cmd_item_t t, int unsigned vs, int mode);
    t.vslot = IDX_W'(vs);
    for (int k = 0; k < 3; k++) begin
      t.p[k] = mode == 1 ? 16'h8000 : mode == 2 ? 16'h7fff : COORD_W'($urandom);
      t.n[k] = mode == 1 ? 16'h7fff : mode == 2 ? 16'h8000 : COORD_W'($urandom);
    end
    return t;
  endfunction

  task automatic push_load(int unsigned vs, int mode);
    pending = {pending, pick_coord(mk(OP_LOAD), vs, mode)};
    loaded[vs] = 1;
  endtask

  task automatic push_tri(int unsigned a, b, c);
    cmd_item_t t;
    t = mk(OP_ADD); t.c[0] = IDX_W'(a); t.c[1] = IDX_W'(b); t.c[2] = IDX_W'(c);
    pending = {pending, t};
  endtask

  task automatic push_query(int unsigned s);
    cmd_item_t t;
    t = mk(OP_QUERY); t.hslot = SLOT_W'(s);
    pending = {pending, t};
  endtask

  task automatic push_cfg(bit v);
    cmd_item_t t;
    t = mk(OP_CLEAR); t.is_cfg = 1; t.cfg_val = v;
    pending = {pending, t};
  endtask

  task automatic wait_drained;
    while (pending.size() > 0 || adj_expected.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // a small closed mesh (tetrahedron) on random loaded vertices plus probes
  task automatic push_mesh_phase(int n_items);
    int unsigned v[4];
    int unsigned lim;
    for (int k = 0; k < 4; k++) begin
      v[k] = $urandom_range(1023);
      push_load(v[k], 0);
    end
    pending = {pending, mk(OP_CLEAR)};
    push_tri(v[0], v[1], v[2]); push_tri(v[0], v[3], v[1]);
    push_tri(v[1], v[3], v[2]); push_tri(v[2], v[3], v[0]);
    lim = 12;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(9))
        0: push_load($urandom_range(1023), 0);
        1, 2: begin
          // corners are drawn from the mesh vertices, falling back to v[0..2] if any is unloaded
          int unsigned a, b, c;
          a = v[$urandom_range(3)]; b = v[$urandom_range(3)]; c = v[$urandom_range(3)];
          if (!loaded[a] || !loaded[b] || !loaded[c]) begin a = v[0]; b = v[1]; c = v[2]; end
          push_tri(b, a, c); lim += 3;
        end
        9: push_query($urandom_range(4095));
        default: push_query($urandom_range(lim + 2));
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: extremes, flips, open edges, unfilled, clear
    push_load(0, 1); push_load(1023, 2); push_load(5, 0); push_load(6, 0);
    push_query(0);
    push_tri(0, 1023, 5); push_tri(1023, 0, 6); push_tri(5, 6, 0);
    push_query(0); push_query(1); push_query(2); push_query(8); push_query(9);
    push_query(4095);
    pending = {pending, mk(OP_CLEAR)};
    push_query(0);
    push_tri(0, 0, 0); push_query(0);
    push_cfg(0);
    push_tri(1023, 1023, 1023); push_tri(1022, 1023, 1023);
    push_query(0); push_query(3); push_query(5);
    wait_drained();
    push_cfg(1);
    send_idle = 0;  recv_stall = 0;  push_mesh_phase(32); wait_drained();
    send_idle = 53; recv_stall = 0;  push_mesh_phase(32); wait_drained();
    push_cfg(0);
    send_idle = 0;  recv_stall = 53; push_mesh_phase(32); wait_drained();
    push_cfg(1);
    send_idle = 21; recv_stall = 21; push_mesh_phase(32); wait_drained();
    if (errors == 0) $display("PASS mesh_edge_adjacency_builder_unit");
    else $display("FAIL mesh_edge_adjacency_builder_unit");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 1000000) begin
      $display("FAIL mesh_edge_adjacency_builder_unit");
      $finish;
    end
  end
endmodule
